@@ src/gmda_pkg.sv @@
package gmda_pkg;

    localparam int unsigned RATE_W  = 16;
    localparam int unsigned GAIN_W  = 24;
    localparam int unsigned STEP_W  = 24;
    localparam int unsigned TOTAL_W = 32;
    localparam int unsigned SUMSQ_W = 32;
    localparam int unsigned MAG_W   = 16;
    localparam int unsigned PROD_W  = MAG_W + GAIN_W;

    // metres per count per interval, 32 fractional bits
    localparam logic [GAIN_W-1:0] GAIN_RESET = 24'd590319;

    // step = product >> STEP_SHIFT
    localparam int unsigned STEP_SHIFT = 16;

    // isqrt: one result bit per round
    localparam int unsigned          SQRT_ROUNDS   = 16;
    localparam logic [SUMSQ_W-1:0]   SQRT_BIT_INIT = 32'h4000_0000;

    typedef struct packed {
        logic busy;
        logic done;
    } sqrt_stat_t;

endpackage

@@ src/gyro_magnitude_distance_accumulator.sv @@
// Gyro distance accumulator. Takes one word of three signed 16-bit raw rates,
// forms floor(sqrt(x^2+y^2+z^2)), scales it by distance_gain (32 fractional
// bits) to a Q8.16 step distance, and adds that to a saturating Q16.16 total;
// restart=1 drops the old total first. One word is in flight at a time and
// in_stall stays high while it is worked on: the squares go through the shared
// multiplier, the bit-serial square root settles and raises its done flag,
// then the block scales the root, writes the result register and returns to
// idle before the next word is taken. The result register lets a new word be
// taken while the previous result waits on out_stall; the write step holds
// until that register is free. distance_gain is written through the cfg
// channel (always ready) and resets to 590319.
module gyro_magnitude_distance_accumulator (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [gmda_pkg::RATE_W-1:0]  rate_x,
    input  logic signed [gmda_pkg::RATE_W-1:0]  rate_y,
    input  logic signed [gmda_pkg::RATE_W-1:0]  rate_z,
    input  logic                                restart,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [gmda_pkg::STEP_W-1:0]         step_distance,
    output logic [gmda_pkg::TOTAL_W-1:0]        running_total,
    output logic                                total_saturated,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [gmda_pkg::GAIN_W-1:0]         cfg_data
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SQUARE = 5'b00010,
        ST_ROOT   = 5'b00100,
        ST_SCALE  = 5'b01000,
        ST_WRITE  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    // latched input word
    logic signed [gmda_pkg::RATE_W-1:0] x_reg, y_reg, z_reg;
    logic                               restart_reg;

    logic [1:0]                         cnt_reg, cnt_next;
    logic [gmda_pkg::SUMSQ_W-1:0]       sum_reg, sum_next;
    logic [gmda_pkg::GAIN_W-1:0]        gain_reg;
    logic [gmda_pkg::TOTAL_W-1:0]       total_reg;

    logic                               out_valid_reg;
    logic [gmda_pkg::STEP_W-1:0]        step_out_reg;

    // shared multiplier operands
    logic signed [gmda_pkg::RATE_W-1:0] axis;
    logic [gmda_pkg::RATE_W:0]          axis_ext;
    logic [gmda_pkg::RATE_W:0]          axis_abs;
    logic [gmda_pkg::MAG_W-1:0]         mul_a;
    logic [gmda_pkg::GAIN_W-1:0]        mul_b;
    logic [gmda_pkg::PROD_W-1:0]        mul_p;

    gmda_pkg::sqrt_stat_t               sqrt_stat;
    logic                               sqrt_start;
    logic [gmda_pkg::MAG_W-1:0]         mag;

    logic                               in_accept;
    logic                               out_free;
    logic                               do_write;
    logic [gmda_pkg::STEP_W-1:0]        step_val;
    logic [gmda_pkg::TOTAL_W-1:0]       base;
    logic [gmda_pkg::TOTAL_W:0]         total_sum;
    logic [gmda_pkg::TOTAL_W-1:0]       total_new;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    // axis select for the three squares
    always_comb
    begin
        case (cnt_reg)
            2'd0:    axis = x_reg;
            2'd1:    axis = y_reg;
            2'd2:    axis = z_reg;
            default: axis = x_reg;
        endcase
    end

    assign axis_ext = {axis[gmda_pkg::RATE_W-1], axis};
    assign axis_abs = axis[gmda_pkg::RATE_W-1] ? (~axis_ext + 1'b1) : axis_ext;

    // squares in SQUARE, magnitude * gain otherwise (held through WRITE)
    always_comb
    begin
        if (state_reg == ST_SQUARE)
        begin
            mul_a = axis_abs[gmda_pkg::MAG_W-1:0];
            mul_b = gmda_pkg::GAIN_W'(axis_abs[gmda_pkg::MAG_W-1:0]);
        end
        else
        begin
            mul_a = mag;
            mul_b = gain_reg;
        end
    end

    gmda_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    // product is registered, so it is added on counts 1..3
    assign sum_next   = (cnt_reg == 2'd0) ? sum_reg
                                          : sum_reg + mul_p[gmda_pkg::SUMSQ_W-1:0];
    assign sqrt_start = (state_reg == ST_SQUARE) && (cnt_reg == 2'd3);

    gmda_isqrt u_isqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (sqrt_start),
        .operand (sum_next),
        .stat    (sqrt_stat),
        .root    (mag)
    );

    // product < 2^40, so the step never overflows 24 bits
    assign step_val  = mul_p[gmda_pkg::STEP_SHIFT +: gmda_pkg::STEP_W];
    assign base      = restart_reg ? '0 : total_reg;
    assign total_sum = {1'b0, base} + (gmda_pkg::TOTAL_W + 1)'(step_val);
    assign total_new = total_sum[gmda_pkg::TOTAL_W] ? '1
                                                    : total_sum[gmda_pkg::TOTAL_W-1:0];

    assign out_free = !out_valid_reg || !out_stall;
    assign do_write = (state_reg == ST_WRITE) && out_free;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                cnt_next = 2'd0;
                if (in_accept)
                begin
                    state_next = ST_SQUARE;
                end
            end
            ST_SQUARE:
            begin
                cnt_next = cnt_reg + 2'd1;
                if (cnt_reg == 2'd3)
                begin
                    state_next = ST_ROOT;
                end
            end
            ST_ROOT:
            begin
                if (sqrt_stat.done)
                begin
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE:
            begin
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= 2'd0;
            gain_reg      <= gmda_pkg::GAIN_RESET;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (cfg_valid && cfg_ready)
            begin
                gain_reg <= cfg_data;
            end
            if (do_write)
            begin
                total_reg     <= total_new;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            x_reg       <= rate_x;
            y_reg       <= rate_y;
            z_reg       <= rate_z;
            restart_reg <= restart;
            sum_reg     <= '0;
        end
        else if (state_reg == ST_SQUARE)
        begin
            sum_reg <= sum_next;
        end
        if (do_write)
        begin
            step_out_reg <= step_val;
        end
    end

    assign out_valid       = out_valid_reg;
    assign step_distance   = step_out_reg;
    assign running_total   = total_reg;
    assign total_saturated = (total_reg == '1);

    // a new result only comes from the write step
    a_rise_from_write: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_WRITE))
        else $error("result appeared outside write step");

    // root done only while the sequencer waits on it
    a_done_in_root: assert property (@(posedge clk) disable iff (!rst_n)
        sqrt_stat.done |-> (state_reg == ST_ROOT))
        else $error("sqrt done outside ROOT");

    // square root is idle whenever a new word may be taken
    a_idle_no_sqrt: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !sqrt_stat.busy)
        else $error("sqrt busy while idle");

    // sqrt starts from SQUARE and is busy in the next cycle
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        sqrt_start |=> (sqrt_stat.busy && (state_reg == ST_ROOT)))
        else $error("sqrt did not start");

endmodule

@@ src/gmda_mul.sv @@
// Shared multiplier, registered product.
module gmda_mul (
    input  logic                              clk,
    input  logic [gmda_pkg::MAG_W-1:0]        a,
    input  logic [gmda_pkg::GAIN_W-1:0]       b,
    output logic [gmda_pkg::PROD_W-1:0]       p
);

    logic [gmda_pkg::PROD_W-1:0] p_reg;
    logic [gmda_pkg::PROD_W-1:0] p_next;

    assign p_next = gmda_pkg::PROD_W'(a) * gmda_pkg::PROD_W'(b);

    always_ff @(posedge clk)
    begin
        p_reg <= p_next;
    end

    assign p = p_reg;

endmodule

@@ src/gmda_isqrt.sv @@
// Floor square root, one bit per cycle.
module gmda_isqrt (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [gmda_pkg::SUMSQ_W-1:0]      operand,
    output gmda_pkg::sqrt_stat_t              stat,
    output logic [gmda_pkg::MAG_W-1:0]        root
);

    localparam int unsigned RW = $clog2(gmda_pkg::SQRT_ROUNDS);

    logic [gmda_pkg::SUMSQ_W-1:0] rem_reg,  rem_next;
    logic [gmda_pkg::SUMSQ_W-1:0] root_reg, root_next;
    logic [gmda_pkg::SUMSQ_W-1:0] bit_reg,  bit_next;
    logic [RW-1:0]                round_reg, round_next;
    logic                         busy_reg, busy_next;
    logic                         done_reg, done_next;
    logic [gmda_pkg::SUMSQ_W-1:0] trial;

    assign trial = root_reg + bit_reg;

    always_comb
    begin
        rem_next   = rem_reg;
        root_next  = root_reg;
        bit_next   = bit_reg;
        round_next = round_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (start)
        begin
            rem_next   = operand;
            root_next  = '0;
            bit_next   = gmda_pkg::SQRT_BIT_INIT;
            round_next = '0;
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            if (rem_reg >= trial)
            begin
                rem_next  = rem_reg - trial;
                root_next = (root_reg >> 1) + bit_reg;
            end
            else
            begin
                root_next = root_reg >> 1;
            end
            bit_next   = bit_reg >> 2;
            round_next = round_reg + RW'(1);
            if (round_reg == RW'(gmda_pkg::SQRT_ROUNDS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            round_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            round_reg <= round_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        root_reg <= root_next;
        bit_reg  <= bit_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign root      = root_reg[gmda_pkg::MAG_W-1:0];

endmodule

@@ tb/gyro_magnitude_distance_accumulator_tb.sv @@
module gyro_magnitude_distance_accumulator_tb;

    // Widths and constants shared with the block.
    localparam int unsigned       RATE_W     = gmda_pkg::RATE_W;
    localparam int unsigned       GAIN_W     = gmda_pkg::GAIN_W;
    localparam int unsigned       STEP_W     = gmda_pkg::STEP_W;
    localparam int unsigned       TOTAL_W    = gmda_pkg::TOTAL_W;
    localparam int unsigned       SUMSQ_W    = gmda_pkg::SUMSQ_W;
    localparam int unsigned       MAG_W      = gmda_pkg::MAG_W;
    localparam int unsigned       PROD_W     = gmda_pkg::PROD_W;
    localparam int unsigned       STEP_SHIFT = gmda_pkg::STEP_SHIFT;
    localparam logic [GAIN_W-1:0] GAIN_RESET = gmda_pkg::GAIN_RESET;

    // ------------------------------------------------------------------
    // Types
    // ------------------------------------------------------------------

    // One result word: interval distance, running total, saturation flag.
    typedef struct packed {
        logic [STEP_W-1:0]  step;
        logic [TOTAL_W-1:0] total;
        logic               sat;
    } odo_t;

    // Directed rows either carry a hand-worked result or lean on the predictor.
    typedef enum logic {CHK_MODEL, CHK_FIXED} chk_t;

    // Random phases: general mix, or long runs of big rates that drive the
    // total into saturation.
    typedef enum logic {MIX_GENERAL, MIX_SATURATE} mix_t;

    // Receiver behavior, picked at random by the stall generator.
    typedef enum logic [1:0] {RX_FREE, RX_LIGHT, RX_HEAVY} rx_mode_t;

    typedef struct packed {
        logic [GAIN_W-1:0]        gain;
        logic signed [RATE_W-1:0] x;
        logic signed [RATE_W-1:0] y;
        logic signed [RATE_W-1:0] z;
        logic                     clear;
        chk_t                     chk;
        odo_t                     fixed;
    } probe_t;

    localparam logic [GAIN_W-1:0] GAIN_TOP  = 24'hFF_FFFF;
    localparam logic [GAIN_W-1:0] GAIN_UNIT = 24'd65536;   // step equals magnitude
    localparam int unsigned       IDLE_PAD  = 32;          // outlasts one word's pass through the block
    localparam int unsigned       N_PROBES  = 24;

    // Directed words. Gain changes between rows are written while idle.
    // Hand-worked rows: at reset gain a magnitude of 1 gives 590319>>16 = 9,
    // a 3-4-5 triangle gives 45; at full gain the largest magnitude 56755 gives
    // 56755*(2^24-1)>>16 = 14529279; at unit gain the step is the magnitude.
    localparam probe_t PROBES [N_PROBES] = '{
        '{GAIN_RESET,      0,      0,      0, 1'b0, CHK_FIXED, '{24'd0,  32'd0,  1'b0}},
        '{GAIN_RESET,      1,      0,      0, 1'b0, CHK_FIXED, '{24'd9,  32'd9,  1'b0}},
        '{GAIN_RESET,      0,     -1,      0, 1'b0, CHK_FIXED, '{24'd9,  32'd18, 1'b0}},
        '{GAIN_RESET,      0,      0,      1, 1'b1, CHK_FIXED, '{24'd9,  32'd9,  1'b0}},
        '{GAIN_RESET,      3,      4,      0, 1'b1, CHK_FIXED, '{24'd45, 32'd45, 1'b0}},
        '{GAIN_RESET,     -3,     -4,     12, 1'b0, CHK_MODEL, '0},
        '{GAIN_RESET,  32767,      0,      0, 1'b0, CHK_MODEL, '0},
        '{GAIN_RESET, -32768,      0,      0, 1'b0, CHK_MODEL, '0},
        '{GAIN_RESET,      0,  32767, -32768, 1'b0, CHK_MODEL, '0},
        '{GAIN_RESET, -32768, -32768, -32768, 1'b0, CHK_MODEL, '0},
        '{GAIN_RESET,  32767,  32767,  32767, 1'b0, CHK_MODEL, '0},
        '{GAIN_RESET,      1,      1,      1, 1'b0, CHK_MODEL, '0},
        '{GAIN_RESET,  21845, -21846,  21845, 1'b0, CHK_MODEL, '0},
        '{GAIN_RESET, -21846,  21845, -21846, 1'b1, CHK_MODEL, '0},
        '{GAIN_RESET,      0,      0,      0, 1'b1, CHK_FIXED, '{24'd0,  32'd0,  1'b0}},
        '{24'd0,      -32768, -32768, -32768, 1'b0, CHK_FIXED, '{24'd0,  32'd0,  1'b0}},
        '{24'd0,       32767,     -1,      1, 1'b1, CHK_FIXED, '{24'd0,  32'd0,  1'b0}},
        '{GAIN_TOP,   -32768, -32768, -32768, 1'b1, CHK_FIXED,
            '{24'd14529279, 32'd14529279, 1'b0}},
        '{GAIN_TOP,   -32768, -32768, -32768, 1'b0, CHK_FIXED,
            '{24'd14529279, 32'd29058558, 1'b0}},
        '{GAIN_TOP,        1,      0,      0, 1'b0, CHK_FIXED,
            '{24'd255, 32'd29058813, 1'b0}},
        '{24'd1,      -32768, -32768, -32768, 1'b1, CHK_FIXED, '{24'd0,  32'd0,  1'b0}},
        '{24'd1,           0,      0,      0, 1'b0, CHK_FIXED, '{24'd0,  32'd0,  1'b0}},
        '{GAIN_UNIT,       2,      0,      0, 1'b0, CHK_FIXED, '{24'd2,  32'd2,  1'b0}},
        '{GAIN_UNIT,  -32768, -32768, -32768, 1'b0, CHK_FIXED,
            '{24'd56755, 32'd56757, 1'b0}}
    };

    // ------------------------------------------------------------------
    // Clock, reset and block I/O. Every input starts at a known value.
    // ------------------------------------------------------------------
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                     in_valid  = 1'b0;
    logic                     in_stall;
    logic signed [RATE_W-1:0] rate_x    = '0;
    logic signed [RATE_W-1:0] rate_y    = '0;
    logic signed [RATE_W-1:0] rate_z    = '0;
    logic                     restart   = 1'b0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic [STEP_W-1:0]        step_distance;
    logic [TOTAL_W-1:0]       running_total;
    logic                     total_saturated;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [GAIN_W-1:0]        cfg_data  = '0;

    // Predictor state: the gain as last written and the accumulated total.
    logic [GAIN_W-1:0]  model_gain  = GAIN_RESET;
    logic [TOTAL_W-1:0] model_total = '0;

    odo_t pending[$];   // expected results, oldest first

    int unsigned words_sent     = 0;
    int unsigned results_seen   = 0;
    int unsigned saturated_seen = 0;
    int unsigned gain_writes    = 0;
    int unsigned mismatch_count = 0;

    // Receiver stall generator state.
    rx_mode_t    rx_mode    = RX_FREE;
    int unsigned mode_left  = 0;
    int unsigned stall_left = 0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    gyro_magnitude_distance_accumulator u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .rate_x          (rate_x),
        .rate_y          (rate_y),
        .rate_z          (rate_z),
        .restart         (restart),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .step_distance   (step_distance),
        .running_total   (running_total),
        .total_saturated (total_saturated),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data)
    );

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Distance for one sample; advances model_total.
    function automatic odo_t predict_distance(logic signed [RATE_W-1:0] x,
                                              logic signed [RATE_W-1:0] y,
                                              logic signed [RATE_W-1:0] z,
                                              logic clear);
        int                  sx;
        int                  sy;
        int                  sz;
        logic [SUMSQ_W-1:0]  sumsq;
        logic [MAG_W-1:0]    mag;
        logic [MAG_W-1:0]    trial;
        logic [SUMSQ_W-1:0]  trial_sq;
        logic [PROD_W-1:0]   prod;
        logic [TOTAL_W:0]    acc;
        odo_t                res;
        sx = x;
        sy = y;
        sz = z;
        // each square is at most 2^30; the sum can use bit 31
        sumsq = SUMSQ_W'(sx * sx) + SUMSQ_W'(sy * sy) + SUMSQ_W'(sz * sz);
        // floor root, settled one bit at a time from the top
        mag = '0;
        for (int b = MAG_W - 1; b >= 0; b--)
        begin
            trial    = mag | (MAG_W'(1) << b);
            trial_sq = SUMSQ_W'(trial) * SUMSQ_W'(trial);
            if (trial_sq <= sumsq)
                mag = trial;
        end
        prod     = PROD_W'(mag) * PROD_W'(model_gain);
        res.step = prod[PROD_W-1:STEP_SHIFT];
        acc      = (clear ? '0 : {1'b0, model_total}) + (TOTAL_W + 1)'(res.step);
        model_total = acc[TOTAL_W] ? '1 : acc[TOTAL_W-1:0];
        res.total = model_total;
        res.sat   = (model_total == '1);
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Sender idle cycles after a word: mostly none or short, now and then long.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 80);
    endfunction

    function automatic logic signed [RATE_W-1:0] pick_rate(mix_t mix);
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (mix == MIX_SATURATE)
        begin
            // |rate| >= 20000 on every axis keeps each step at or above 8.8M at full gain
            if (sel[0])
                return RATE_W'($urandom_range(20000, 32767));
            else
                return RATE_W'(0 - $urandom_range(20000, 32768));
        end
        if (sel < 5)
            return RATE_W'($urandom);
        if (sel < 7)
        begin
            case ($urandom_range(0, 5))
                0:       return RATE_W'(-32768);
                1:       return RATE_W'(-32767);
                2:       return RATE_W'(-1);
                3:       return RATE_W'(0);
                4:       return RATE_W'(1);
                default: return RATE_W'(32767);
            endcase
        end
        if (sel < 9)
            return RATE_W'(int'($urandom_range(0, 128)) - 64);
        // near full scale, either sign
        if ($urandom_range(0, 1) == 0)
            return RATE_W'(32767 - $urandom_range(0, 2000));
        return RATE_W'(0 - (32767 - $urandom_range(0, 2000)));
    endfunction

    // Present one word, hold it until taken, log its expected result.
    task automatic send_word(input logic signed [RATE_W-1:0] x,
                             input logic signed [RATE_W-1:0] y,
                             input logic signed [RATE_W-1:0] z,
                             input logic                     clear,
                             input chk_t                     chk,
                             input odo_t                     fixed);
        odo_t        guess;
        int unsigned gap;
        @(negedge clk);
        in_valid <= 1'b1;
        rate_x   <= x;
        rate_y   <= y;
        rate_z   <= z;
        restart  <= clear;
        do
            @(posedge clk);
        while (in_stall);
        guess = predict_distance(x, y, z, clear);
        pending.push_back(chk == CHK_FIXED ? fixed : guess);
        words_sent++;
        gap = pick_gap();
        if (gap != 0)
        begin
            @(negedge clk) in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // Stop sending and wait for every outstanding result, then let the
    // pipeline settle.
    task automatic drain();
        @(negedge clk) in_valid <= 1'b0;
        while (pending.size() != 0)
            @(posedge clk);
        repeat (IDLE_PAD) @(posedge clk);
    endtask

    // Gain write; callers make sure the block is idle first.
    task automatic write_gain(input logic [GAIN_W-1:0] g);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= g;
        do
            @(posedge clk);
        while (!cfg_ready);
        model_gain = g;
        gain_writes++;
        @(negedge clk) cfg_valid <= 1'b0;
    endtask

    // One random phase at a fixed gain.
    task automatic run_phase(input logic [GAIN_W-1:0] g, input int unsigned count,
                             input mix_t mix);
        logic clear;
        drain();
        write_gain(g);
        for (int unsigned i = 0; i < count; i++)
        begin
            if (mix == MIX_SATURATE)
                // start from zero, climb past the top, then clear while pinned
                clear = (i == 0) || (i == count - 10);
            else
                clear = ($urandom_range(0, 15) == 0);
            send_word(pick_rate(mix), pick_rate(mix), pick_rate(mix), clear,
                      CHK_MODEL, '0);
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver stall: free stretches, light chatter, or heavy with long holds
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (mode_left == 0)
        begin
            rx_mode   = rx_mode_t'($urandom_range(0, 2));
            mode_left = $urandom_range(100, 400);
        end
        mode_left--;
        if (stall_left == 0)
        begin
            case (rx_mode)
                RX_LIGHT:
                    if ($urandom_range(0, 3) == 0)
                        stall_left = $urandom_range(1, 3);
                RX_HEAVY:
                    if ($urandom_range(0, 29) == 0)
                        stall_left = $urandom_range(15, 60);
                    else if ($urandom_range(0, 5) == 0)
                        stall_left = $urandom_range(1, 4);
                default:
                    ;
            endcase
        end
        if (stall_left != 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else
            out_stall <= 1'b0;
    end

    // ------------------------------------------------------------------
    // Result checker: every accepted word against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        odo_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (pending.size() == 0)
            begin
                $error("unexpected result word: step_distance %0d running_total %0d",
                       step_distance, running_total);
                mismatch_count++;
            end
            else
            begin
                want = pending.pop_front();
                if (step_distance !== want.step)
                begin
                    $error("step_distance: expected %0d, got %0d", want.step,
                           step_distance);
                    mismatch_count++;
                end
                if (running_total !== want.total)
                begin
                    $error("running_total: expected %0d, got %0d", want.total,
                           running_total);
                    mismatch_count++;
                end
                if (total_saturated !== want.sat)
                begin
                    $error("total_saturated: expected %0d, got %0d", want.sat,
                           total_saturated);
                    mismatch_count++;
                end
                if (want.sat)
                    saturated_seen++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        // directed words; gain steps reset -> 0 -> max -> 1 -> unit
        foreach (PROBES[i])
        begin
            if (PROBES[i].gain != model_gain)
            begin
                drain();
                write_gain(PROBES[i].gain);
            end
            send_word(PROBES[i].x, PROBES[i].y, PROBES[i].z, PROBES[i].clear,
                      PROBES[i].chk, PROBES[i].fixed);
        end

        // random phases; each one starts from an empty pipeline
        run_phase(GAIN_W'($urandom), 400, MIX_GENERAL);
        run_phase(GAIN_TOP, 520, MIX_SATURATE);
        run_phase('0, 50, MIX_GENERAL);
        run_phase(24'd1, 50, MIX_GENERAL);
        run_phase(GAIN_W'($urandom), 150, MIX_GENERAL);
        run_phase(GAIN_W'($urandom), 150, MIX_GENERAL);
        run_phase(GAIN_RESET, 150, MIX_GENERAL);
        run_phase(GAIN_W'($urandom), 150, MIX_GENERAL);
        drain();

        $display("sent %0d words across %0d gain writes, checked %0d results",
                 words_sent, gain_writes, results_seen);
        $display("%0d results at the saturated total, %0d mismatches",
                 saturated_seen, mismatch_count);
        if (mismatch_count == 0 && pending.size() == 0)
            $display("gyro_magnitude_distance_accumulator_tb passed");
        else
            $display("gyro_magnitude_distance_accumulator_tb failed");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #10000000;
        $display("gyro_magnitude_distance_accumulator_tb failed");
        $finish;
    end

endmodule
